>>> hw/rtl/sha256_message_hasher_macros.svh
// assertion macros for the sha-256 message hasher
// expects clk_i and rst_ni to be visible at the point of use
`ifndef SHA256_MESSAGE_HASHER_MACROS_SVH
`define SHA256_MESSAGE_HASHER_MACROS_SVH

// same-cycle implication, checked out of reset
`define SHA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sha256 hasher: same-cycle check failed");

// next-cycle implication, checked out of reset
`define SHA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sha256 hasher: next-cycle check failed");

`endif

>>> hw/rtl/sha_pkg.sv
// shared types and constants of the sha-256 message hasher
// beat payloads, round-unit control struct, round constants, initial hash
package sha_pkg;

  // command codes of an input beat
  localparam logic CmdAbsorb = 1'b0;
  localparam logic CmdFinish = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } sha_in_t;

  typedef struct packed {
    logic [2:0]  word_index;
    logic [31:0] digest_word;
    logic        last_word;
  } sha_out_t;

  // control from the sequencer to the round unit
  typedef struct packed {
    logic       shift_byte;
    logic [7:0] byte_val;
    logic       start;
    logic       round_en;
    logic [5:0] round;
  } sha_ctl_t;

  localparam logic [31:0] ShaHInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ShaK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

>>> hw/rtl/sha256_message_hasher.sv
// sha-256 message hasher top level: sequencer, hash state, length and digest beats
// depends on sha_pkg, sha_core and sha256_message_hasher_macros.svh
//
//   channel | valid      | stall       | payload
//   --------+------------+-------------+----------------------------------------
//   in      | in_valid_i | in_stall_o  | in_data_i  (command, data_byte)
//   out     | out_valid_o| out_stall_i | out_data_o (word_index, digest_word, last_word)
//
// an absorb beat is taken while idle; the beat that fills a block starts a compression
// (64 rounds on the shared round unit, then the hash update)
// finish pads one byte per cycle outside compressions up to the length bytes at byte
// 56, then shifts in the length bytes and compresses, then gives 8 digest beats
// reset loads the initial hash and clears the byte count; no memory clearing
// in_stall_o is high whenever the sequencer is busy; out_stall_i holds a beat
`include "sha256_message_hasher_macros.svh"

module sha256_message_hasher (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sha_pkg::sha_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sha_pkg::sha_out_t out_data_o
);
  import sha_pkg::*;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StPad   = 6'b000010,
    StLen   = 6'b000100,
    StRound = 6'b001000,
    StAdd   = 6'b010000,
    StEmit  = 6'b100000
  } sha_state_e;

  // where the sequencer goes after a compression
  typedef enum logic [1:0] {
    RetIdle = 2'd0,
    RetPad  = 2'd1,
    RetEmit = 2'd2
  } sha_ret_e;

  localparam logic [5:0] FillLast  = 6'd63;
  localparam logic [5:0] LenPos    = 6'd56;
  localparam logic [5:0] RoundLast = 6'd63;
  localparam logic [2:0] WordLast  = 3'd7;
  localparam logic [7:0] PadByte   = 8'h80;

  sha_state_e  state_q, state_d;
  sha_ret_e    ret_q, ret_d;
  logic [5:0]  fill_q, fill_d;
  logic [5:0]  round_q, round_d;
  logic [63:0] count_q, count_d;
  logic [63:0] bits_q, bits_d;
  logic [2:0]  idx_q, idx_d;
  logic [31:0] hash_q [8];
  logic [31:0] hash_d [8];
  logic [31:0] wv [8];
  sha_ctl_t    ctl;
  logic        in_acc, out_acc;

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StEmit);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_acc     = out_valid_o & ~out_stall_i;

  assign out_data_o.word_index  = idx_q;
  assign out_data_o.digest_word = hash_q[0];
  assign out_data_o.last_word   = (idx_q == WordLast);

  sha_core u_core (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .hash_i (hash_q),
    .wv_o   (wv)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    fill_d  = fill_q;
    round_d = round_q;
    count_d = count_q;
    bits_d  = bits_q;
    idx_d   = idx_q;
    hash_d  = hash_q;
    ctl     = '0;
    ctl.round = round_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          ctl.shift_byte = 1'b1;
          fill_d = fill_q + 6'd1;
          if (in_data_i.command == CmdAbsorb) begin
            ctl.byte_val = in_data_i.data_byte;
            count_d = count_q + 64'd1;
            ret_d   = RetIdle;
          end else begin
            ctl.byte_val = PadByte;
            bits_d  = {count_q[60:0], 3'b000};
            count_d = '0;
            ret_d   = RetPad;
            state_d = StPad;
          end
          if (fill_q == FillLast) begin
            ctl.start = 1'b1;
            round_d   = '0;
            state_d   = StRound;
          end
        end
      end
      StPad: begin
        if (fill_q == LenPos) begin
          state_d = StLen;
        end else begin
          ctl.shift_byte = 1'b1;
          fill_d = fill_q + 6'd1;
          if (fill_q == FillLast) begin
            ctl.start = 1'b1;
            round_d   = '0;
            ret_d     = RetPad;
            state_d   = StRound;
          end
        end
      end
      StLen: begin
        // bit length, most significant byte first
        ctl.shift_byte = 1'b1;
        ctl.byte_val   = bits_q[63:56];
        bits_d = {bits_q[55:0], 8'h00};
        fill_d = fill_q + 6'd1;
        if (fill_q == FillLast) begin
          ctl.start = 1'b1;
          round_d   = '0;
          ret_d     = RetEmit;
          state_d   = StRound;
        end
      end
      StRound: begin
        ctl.round_en = 1'b1;
        round_d = round_q + 6'd1;
        if (round_q == RoundLast) begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        for (int i = 0; i < 8; i++) begin
          hash_d[i] = hash_q[i] + wv[i];
        end
        case (ret_q)
          RetPad: state_d = StPad;
          RetEmit: begin
            idx_d   = '0;
            state_d = StEmit;
          end
          default: state_d = StIdle;
        endcase
      end
      StEmit: begin
        // rotate digest out of word 0, refill with the initial hash
        if (out_acc) begin
          for (int i = 0; i < 7; i++) begin
            hash_d[i] = hash_q[i + 1];
          end
          hash_d[7] = ShaHInit[idx_q];
          idx_d = idx_q + 3'd1;
          if (idx_q == WordLast) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control and hash state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ret_q   <= RetIdle;
      fill_q  <= '0;
      round_q <= '0;
      count_q <= '0;
      idx_q   <= '0;
      hash_q  <= ShaHInit;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      fill_q  <= fill_d;
      round_q <= round_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      hash_q  <= hash_d;
    end
  end

  // length word for padding
  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
  end

  // checks
  `SHA_ASSERT_IMP(a_no_in_while_out, out_valid_o, in_stall_o)
  `SHA_ASSERT_NXT(a_finish_busy, in_acc && (in_data_i.command == CmdFinish), in_stall_o)
  `SHA_ASSERT_NXT(a_last_ends, out_acc && out_data_o.last_word, !out_valid_o)
  `SHA_ASSERT_NXT(a_idx_step, out_acc && !out_data_o.last_word, out_valid_o && (out_data_o.word_index == ($past(out_data_o.word_index) + 3'd1)))

endmodule

>>> hw/rtl/sha_core.sv
// sha-256 round unit: 512-bit block/schedule shift line and working variables
// one round per enabled cycle; depends on sha_pkg
module sha_core (
  input  logic             clk_i,
  input  sha_pkg::sha_ctl_t ctl_i,
  input  logic [31:0]      hash_i [8],
  output logic [31:0]      wv_o [8]
);
  import sha_pkg::*;

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  // block bytes enter at the bottom; schedule word k sits at bits 511-32k
  logic [511:0] buf_q;
  logic [31:0]  wv_q [8];

  logic [31:0] w0, w1, w9, w14;
  logic [31:0] new_w, t1, t2, ch, maj;

  assign w0  = buf_q[511:480];
  assign w1  = buf_q[479:448];
  assign w9  = buf_q[223:192];
  assign w14 = buf_q[63:32];

  // next schedule word and round sums
  always_comb begin
    new_w = ssig1(w14) + w9 + ssig0(w1) + w0;
    ch    = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
    maj   = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
    t1    = wv_q[7] + bsig1(wv_q[4]) + ch + ShaK[ctl_i.round] + w0;
    t2    = bsig0(wv_q[0]) + maj;
  end

  // byte packing and schedule shifting share one shift line
  always_ff @(posedge clk_i) begin
    if (ctl_i.shift_byte) begin
      buf_q <= {buf_q[503:0], ctl_i.byte_val};
    end else if (ctl_i.round_en) begin
      buf_q <= {buf_q[479:0], new_w};
    end
  end

  // working variables a..h
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      wv_q <= hash_i;
    end else if (ctl_i.round_en) begin
      wv_q[7] <= wv_q[6];
      wv_q[6] <= wv_q[5];
      wv_q[5] <= wv_q[4];
      wv_q[4] <= wv_q[3] + t1;
      wv_q[3] <= wv_q[2];
      wv_q[2] <= wv_q[1];
      wv_q[1] <= wv_q[0];
      wv_q[0] <= t1 + t2;
    end
  end

  assign wv_o = wv_q;

endmodule

>>> tb/tb_sha256_message_hasher.sv
// self-checking testbench for the streaming sha-256 message hasher
// depends on sha_pkg for the beat payload types and command codes
`timescale 1ns / 1ps

module tb_sha256_message_hasher;
  import sha_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 300;

  localparam logic [31:0] HashInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // message lengths around the padding and block boundaries
  localparam int BoundaryLen [7] = '{55, 56, 57, 62, 63, 64, 65};

  typedef struct packed {
    logic    drain_first;
    sha_in_t beat;
  } feed_beat_t;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  sha_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  sha_out_t out_data_o;

  sha256_message_hasher DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // pending input beats and digest words still due
  feed_beat_t  byte_feed [$];
  sha_out_t    digest_due [$];

  // mirror of the hashing state
  logic [31:0] hash_state [8];
  logic [7:0]  block_bytes [64];
  logic [63:0] msg_len;

  logic        in_beat_taken;
  logic        out_beat_taken;
  logic        out_seen;
  logic [31:0] cycle_count;
  int          quiet_cycles;
  int          mismatch_count;
  int          send_gap;
  int          recv_wait;
  int          fed_count;

  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic int idle_draw(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 7));
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // one 64-round compression of the current block into the hash state
  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) begin
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[r] + w[r];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    logic [5:0] fill;
    fill = msg_len[5:0];
    block_bytes[fill] = b;
    msg_len = msg_len + 64'd1;
    if (fill == 6'd63) compress_block();
  endtask

  // padding, length, final compressions and the eight digest words
  task automatic finish_message();
    logic [5:0]  fill;
    logic [63:0] bit_len;
    sha_out_t    word;
    fill = msg_len[5:0];
    bit_len = msg_len << 3;
    block_bytes[fill] = 8'h80;
    for (int i = fill + 1; i < 64; i++) block_bytes[i] = 8'h00;
    if (fill >= 6'd56) begin
      compress_block();
      for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
    end
    for (int i = 0; i < 8; i++) block_bytes[56+i] = bit_len[63-8*i -: 8];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      word.word_index  = i[2:0];
      word.digest_word = hash_state[i];
      word.last_word   = (i == 7);
      digest_due.push_back(word);
    end
    for (int i = 0; i < 8; i++) hash_state[i] = HashInit[i];
    msg_len = '0;
  endtask

  task automatic queue_byte(input logic [7:0] b, input bit drain);
    feed_beat_t fb;
    fb.drain_first = drain;
    fb.beat.command = CmdAbsorb;
    fb.beat.data_byte = b;
    byte_feed.push_back(fb);
    fed_count++;
  endtask

  // finish beats carry a random byte that the block must ignore
  task automatic queue_finish(input bit drain);
    feed_beat_t fb;
    fb.drain_first = drain;
    fb.beat.command = CmdFinish;
    fb.beat.data_byte = 8'($urandom_range(0, 255));
    byte_feed.push_back(fb);
    fed_count++;
  endtask

  task automatic queue_message(input int len, input bit drain);
    for (int i = 0; i < len; i++) queue_byte(8'($urandom_range(0, 255)), drain && i == 0);
    queue_finish(drain && len == 0);
  endtask

  // monitor: predict accepted input beats, check accepted digest beats
  always @(posedge clk_i) begin
    sha_out_t want;
    in_beat_taken = 1'b0;
    out_beat_taken = 1'b0;
    if (rst_ni) begin
      cycle_count = cycle_count + 1;
      out_seen = out_valid_o;
      if (in_valid_i && !in_stall_o) begin
        in_beat_taken = 1'b1;
        if (in_data_i.command == CmdAbsorb) absorb_byte(in_data_i.data_byte);
        else finish_message();
      end
      if (out_valid_o && !out_stall_i) begin
        out_beat_taken = 1'b1;
        if (digest_due.size() == 0) begin
          note_mismatch("digest beat with none due", out_data_o.digest_word, '0);
        end else begin
          want = digest_due.pop_front();
          if (out_data_o.word_index != want.word_index)
            note_mismatch("word_index", 32'(out_data_o.word_index), 32'(want.word_index));
          if (out_data_o.digest_word != want.digest_word)
            note_mismatch("digest_word", out_data_o.digest_word, want.digest_word);
          if (out_data_o.last_word != want.last_word)
            note_mismatch("last_word", 32'(out_data_o.last_word), 32'(want.last_word));
        end
      end
      // watchdog on cycles with no beat on either side
      if (in_beat_taken || out_beat_taken) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("sha256_message_hasher verification failed");
          $finish;
        end
      end
    end
  end

  // driver: present the next pending beat after its gap
  always @(negedge clk_i) begin
    logic       present;
    feed_beat_t nxt;
    if (rst_ni) begin
      present = in_valid_i && !in_beat_taken;
      if (!present) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (byte_feed.size() != 0 &&
                     !(byte_feed[0].drain_first && digest_due.size() != 0)) begin
          nxt = byte_feed.pop_front();
          in_data_i <= nxt.beat;
          present = 1'b1;
          send_gap = idle_draw(cycle_count[9:8] == 2'd1 || cycle_count[9:8] == 2'd3);
        end
      end
      in_valid_i <= present;
    end
  end

  // receiver: stall each digest beat for a drawn number of cycles
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_beat_taken) begin
        recv_wait = idle_draw(cycle_count[9:8] == 2'd2 || cycle_count[9:8] == 2'd3);
      end else if (out_seen && recv_wait > 0) begin
        recv_wait--;
      end
      out_stall_i <= (recv_wait > 0);
    end
  end

  initial begin
    int len;
    int msg_total;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    in_beat_taken = 1'b0;
    out_beat_taken = 1'b0;
    out_seen = 1'b0;
    cycle_count = '0;
    quiet_cycles = 0;
    mismatch_count = 0;
    send_gap = 0;
    recv_wait = 0;
    fed_count = 0;
    msg_len = '0;
    for (int i = 0; i < 8; i++) hash_state[i] = HashInit[i];
    for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;

    // directed: empty messages back to back, "abc", extreme byte values
    queue_finish(1'b0);
    queue_finish(1'b0);
    queue_byte(8'h61, 1'b0);
    queue_byte(8'h62, 1'b0);
    queue_byte(8'h63, 1'b0);
    queue_finish(1'b0);
    // sender holds here until every digest word has come back
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h7f, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_finish(1'b0);

    // random messages weighted toward padding boundaries
    msg_total = 0;
    while (fed_count < 320 || msg_total < 8) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: len = $urandom_range(0, 10);
        4, 5, 6:    len = BoundaryLen[$urandom_range(0, 6)];
        7:          len = $urandom_range(116, 128);
        default:    len = $urandom_range(11, 70);
      endcase
      queue_message(len, $urandom_range(0, 3) == 0);
      msg_total++;
    end

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (byte_feed.size() != 0 || in_valid_i) @(negedge clk_i);
    while (digest_due.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (mismatch_count == 0) begin
      $display("sha256_message_hasher verification clean");
    end else begin
      $display("sha256_message_hasher verification failed");
    end
    $finish;
  end

endmodule
